// ===== rtl/ectd_pkg.sv =====
// ----------------------------------------------------------------------------
// ectd_pkg: shared types and constants
// Command and status types, divisor and month tables, width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ectd_pkg;

	localparam int STAMP_BITS_DEF = 44;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TZ_HOURS = 1'b0;

	localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
	localparam int OFF_W = 26;
	localparam int REM_W = 18;

	localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
	localparam logic [REM_W-1:0] ERA_LAST_DAY = 18'd146096;
	localparam logic [REM_W-1:0] CENT_DAYS = 18'd36524;
	localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [8:0] JAN_FIRST_DOY = 9'd306;

	typedef enum logic [2:0] {
		DIV_MS,
		DIV_SEC,
		DIV_MIN,
		DIV_HOUR,
		DIV_WEEK,
		DIV_ERA,
		DIV_CYCLE,
		DIV_YEAR
	} div_op_t;

	localparam logic [REM_W-1:0] DIVISOR [8] = '{
		18'd1000, 18'd60, 18'd60, 18'd24, 18'd7, 18'd146097, 18'd1460, 18'd365
	};

	// first day of each month in a year that starts on March 1
	localparam logic [8:0] MONTH_BASE [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

	typedef struct packed {
		logic    load;
		logic    adjust;
		logic    step;
		logic    next;
		logic    cal1;
		logic    cal2;
		div_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic uflow;
	} dp_stat_t;

	function automatic int data_width(int stamp_bits);
		return ((stamp_bits + 4) >> 2) << 2;
	endfunction

	function automatic int div_width(int stamp_bits, div_op_t op);
		int w0;
		int w;
		w0 = stamp_bits + 1;
		case (op)
			DIV_MS:    w = w0;
			DIV_SEC:   w = w0 - 9;
			DIV_MIN:   w = w0 - 14;
			DIV_HOUR:  w = w0 - 19;
			DIV_WEEK:  w = w0 - 23;
			DIV_ERA:   w = ((w0 - 23 > 20) ? w0 - 23 : 20) + 1;
			DIV_CYCLE: w = REM_W;
			DIV_YEAR:  w = REM_W;
			default:   w = w0;
		endcase
		return w;
	endfunction

	function automatic int div_digits(int stamp_bits, div_op_t op);
		return (div_width(stamp_bits, op) + 3) >> 2;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ectd_regs.sv =====
// ----------------------------------------------------------------------------
// ectd_regs: configuration register file
// APB-style slave holding the signed timezone offset in hours.
// ----------------------------------------------------------------------------
`default_nettype none

module ectd_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ectd_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ectd_pkg::PDATA_W-1:0]  pwdata,
	output logic      [ectd_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output logic signed [4:0]                  tz_hours
);
	import ectd_pkg::*;

	logic signed [4:0] tz_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TZ_HOURS);
	assign tz_hours = tz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
		end else if (wr_en) begin
			tz_q <= pwdata[4:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_TZ_HOURS) begin
			prdata = {{(PDATA_W-5){tz_q[4]}}, tz_q};
		end else begin
			prdata = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ectd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ectd_ctrl: conversion sequencer
// Walks the datapath through offset, eight divisions and the calendar steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ectd_ctrl #(
	parameter int STAMP_BITS = ectd_pkg::STAMP_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output ectd_pkg::dp_cmd_t       cmd,
	input  wire ectd_pkg::dp_stat_t stat
);
	import ectd_pkg::*;

	localparam int DW      = data_width(STAMP_BITS);
	localparam int MAX_DIG = DW >> 2;
	localparam int DIG_W   = $clog2(MAX_DIG + 1);

	localparam logic [DIG_W-1:0] DIGITS [8] = '{
		DIG_W'(div_digits(STAMP_BITS, DIV_MS)),
		DIG_W'(div_digits(STAMP_BITS, DIV_SEC)),
		DIG_W'(div_digits(STAMP_BITS, DIV_MIN)),
		DIG_W'(div_digits(STAMP_BITS, DIV_HOUR)),
		DIG_W'(div_digits(STAMP_BITS, DIV_WEEK)),
		DIG_W'(div_digits(STAMP_BITS, DIV_ERA)),
		DIG_W'(div_digits(STAMP_BITS, DIV_CYCLE)),
		DIG_W'(div_digits(STAMP_BITS, DIV_YEAR))
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADJ,
		S_STEP,
		S_NEXT,
		S_CAL1,
		S_CAL2,
		S_DONE
	} state_t;

	state_t           state_q;
	div_op_t          op_q;
	div_op_t          op_nxt;
	logic [DIG_W-1:0] dig_q;

	assign op_nxt = div_op_t'(op_q + 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= DIV_MS;
			dig_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					if (stat.uflow) begin
						state_q <= S_DONE;
					end else begin
						op_q    <= DIV_MS;
						dig_q   <= DIGITS[DIV_MS];
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					dig_q <= dig_q - DIG_W'(1);
					if (dig_q == DIG_W'(1)) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (op_q == DIV_YEAR) begin
						state_q <= S_CAL1;
					end else begin
						op_q    <= op_nxt;
						dig_q   <= DIGITS[op_nxt];
						state_q <= S_STEP;
					end
				end
				S_CAL1: state_q <= S_CAL2;
				S_CAL2: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		cmd        = '0;
		cmd.op     = op_q;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.adjust = (state_q == S_ADJ);
		cmd.step   = (state_q == S_STEP);
		cmd.next   = (state_q == S_NEXT);
		cmd.cal1   = (state_q == S_CAL1);
		cmd.cal2   = (state_q == S_CAL2);
	end

endmodule

`default_nettype wire

// ===== rtl/ectd_dp.sv =====
// ----------------------------------------------------------------------------
// ectd_dp: conversion datapath
// Offset adder, shared radix-16 constant divider and calendar arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ectd_dp #(
	parameter int STAMP_BITS = ectd_pkg::STAMP_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic [STAMP_BITS-1:0] timestamp_ms,
	input  wire logic signed [4:0]     tz_hours,
	input  wire ectd_pkg::dp_cmd_t     cmd,
	output ectd_pkg::dp_stat_t         stat,
	output logic [9:0]                 millis,
	output logic [5:0]                 seconds,
	output logic [5:0]                 minutes,
	output logic [4:0]                 hours,
	output logic [2:0]                 weekday,
	output logic [11:0]                year,
	output logic [8:0]                 day_of_year,
	output logic [3:0]                 month,
	output logic [4:0]                 day_of_month,
	output logic                       underflow
);
	import ectd_pkg::*;

	localparam int W0     = STAMP_BITS + 1;
	localparam int DW     = data_width(STAMP_BITS);
	localparam int DAYS_W = STAMP_BITS - 25;

	localparam int SH [8] = '{
		DW - 4 * div_digits(STAMP_BITS, DIV_MS),
		DW - 4 * div_digits(STAMP_BITS, DIV_SEC),
		DW - 4 * div_digits(STAMP_BITS, DIV_MIN),
		DW - 4 * div_digits(STAMP_BITS, DIV_HOUR),
		DW - 4 * div_digits(STAMP_BITS, DIV_WEEK),
		DW - 4 * div_digits(STAMP_BITS, DIV_ERA),
		DW - 4 * div_digits(STAMP_BITS, DIV_CYCLE),
		DW - 4 * div_digits(STAMP_BITS, DIV_YEAR)
	};

	logic [STAMP_BITS-1:0] stamp_q;
	logic [OFF_W-1:0]      off_q;
	logic                  neg_q;
	logic                  uflow_q;
	logic [DW-1:0]         num_q;
	logic [REM_W-1:0]      rem_q;
	logic [9:0]            ms_q;
	logic [5:0]            sec_q;
	logic [5:0]            min_q;
	logic [4:0]            hrs_q;
	logic [2:0]            wday_q;
	logic [DAYS_W-1:0]     days_q;
	logic [11:0]           era_q;
	logic [REM_W-1:0]      doe_q;
	logic [8:0]            yoe_q;
	logic [8:0]            doym_q;
	logic [3:0]            month_q;
	logic [4:0]            mday_q;
	logic [11:0]           year_q;
	logic [8:0]            doy_q;

	logic [4:0]            tz_mag;
	logic [26:0]           off_full;
	logic [W0-1:0]         stamp_x;
	logic [W0-1:0]         off_x;
	logic [W0-1:0]         t_adj;
	logic                  uflow_now;

	logic [REM_W-1:0]      dvsr;
	logic [REM_W-1:0]      step_r;
	logic [REM_W:0]        trial;
	logic [DW-1:0]         step_n;

	logic [2:0]            cent;
	logic [REM_W-1:0]      a_val;
	logic [DW-1:0]         nxt_val;
	logic [DW-1:0]         num_load;
	div_op_t               nxt_op;
	logic [3:0]            wday_sum;
	logic [2:0]            wday_nxt;

	logic [1:0]            c100;
	logic [REM_W-1:0]      y365;
	logic [REM_W-1:0]      doym_full;

	logic [3:0]            mp;
	logic                  jan_feb;
	logic                  leap;
	logic [8:0]            mday_full;

	// offset
	assign tz_mag    = tz_hours[4] ? 5'(~tz_hours + 5'd1) : 5'(tz_hours);
	assign off_full  = 27'(tz_mag) * 27'(MS_PER_HOUR);
	assign stamp_x   = W0'(stamp_q);
	assign off_x     = W0'(off_q);
	assign t_adj     = neg_q ? (stamp_x - off_x) : (stamp_x + off_x);
	assign uflow_now = neg_q && (stamp_x < off_x);
	assign stat.uflow = uflow_now;

	// one quotient digit per cycle
	always_comb begin
		dvsr   = DIVISOR[cmd.op];
		step_r = rem_q;
		step_n = num_q;
		trial  = '0;
		for (int i = 0; i < 4; i++) begin
			trial  = {step_r, step_n[DW-1]};
			step_n = {step_n[DW-2:0], 1'b0};
			if (trial >= {1'b0, dvsr}) begin
				trial     = trial - {1'b0, dvsr};
				step_n[0] = 1'b1;
			end
			step_r = trial[REM_W-1:0];
		end
	end

	// next dividend
	always_comb begin
		if (doe_q >= ERA_LAST_DAY) begin
			cent = 3'd4;
		end else if (doe_q >= 18'(3 * CENT_DAYS)) begin
			cent = 3'd3;
		end else if (doe_q >= 18'(2 * CENT_DAYS)) begin
			cent = 3'd2;
		end else if (doe_q >= CENT_DAYS) begin
			cent = 3'd1;
		end else begin
			cent = 3'd0;
		end
		a_val = doe_q - REM_W'(num_q[6:0]) + REM_W'(cent)
			- REM_W'(doe_q == ERA_LAST_DAY);
		case (cmd.op)
			DIV_MS, DIV_SEC, DIV_MIN, DIV_HOUR: nxt_val = num_q;
			DIV_WEEK:  nxt_val = DW'(days_q) + DW'(DAYS_TO_EPOCH);
			DIV_ERA:   nxt_val = DW'(rem_q);
			DIV_CYCLE: nxt_val = DW'(a_val);
			default:   nxt_val = '0;
		endcase
		nxt_op   = div_op_t'(cmd.op + 3'd1);
		num_load = nxt_val << SH[nxt_op];
		wday_sum = 4'(rem_q[2:0]) + 4'(EPOCH_WEEKDAY);
		wday_nxt = (wday_sum >= 4'd7) ? 3'(wday_sum - 4'd7) : wday_sum[2:0];
	end

	// day within the March-based year
	always_comb begin
		if (yoe_q >= 9'd300) begin
			c100 = 2'd3;
		end else if (yoe_q >= 9'd200) begin
			c100 = 2'd2;
		end else if (yoe_q >= 9'd100) begin
			c100 = 2'd1;
		end else begin
			c100 = 2'd0;
		end
		y365      = REM_W'(yoe_q) * 18'd365;
		doym_full = doe_q - (y365 + REM_W'(yoe_q[8:2]) - REM_W'(c100));
	end

	// month search
	always_comb begin
		mp = '0;
		for (int i = 1; i < 12; i++) begin
			if (doym_q >= MONTH_BASE[i]) begin
				mp = 4'(i);
			end
		end
		jan_feb   = (mp >= 4'd10);
		leap      = (yoe_q[1:0] == 2'b00) && (yoe_q != 9'd100) && (yoe_q != 9'd200)
			&& (yoe_q != 9'd300);
		mday_full = doym_q - MONTH_BASE[mp] + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q <= timestamp_ms;
			off_q   <= off_full[OFF_W-1:0];
			neg_q   <= tz_hours[4];
		end
		if (cmd.adjust) begin
			uflow_q <= uflow_now;
			num_q   <= DW'(t_adj);
			rem_q   <= '0;
		end
		if (cmd.step) begin
			num_q <= step_n;
			rem_q <= step_r;
		end
		if (cmd.next) begin
			num_q <= num_load;
			rem_q <= '0;
			case (cmd.op)
				DIV_MS:  ms_q  <= rem_q[9:0];
				DIV_SEC: sec_q <= rem_q[5:0];
				DIV_MIN: min_q <= rem_q[5:0];
				DIV_HOUR: begin
					hrs_q  <= rem_q[4:0];
					days_q <= num_q[DAYS_W-1:0];
				end
				DIV_WEEK: wday_q <= wday_nxt;
				DIV_ERA: begin
					era_q <= num_q[11:0];
					doe_q <= rem_q;
				end
				DIV_YEAR: yoe_q <= num_q[8:0];
				default: ;
			endcase
		end
		if (cmd.cal1) begin
			doym_q <= doym_full[8:0];
		end
		if (cmd.cal2) begin
			month_q <= jan_feb ? (mp - 4'd9) : (mp + 4'd3);
			mday_q  <= mday_full[4:0];
			year_q  <= era_q * 12'd400 + 12'(yoe_q) + 12'(jan_feb);
			doy_q   <= jan_feb ? (doym_q - JAN_FIRST_DOY + 9'd1)
				: (doym_q + 9'd60 + 9'(leap));
		end
	end

	assign underflow    = uflow_q;
	assign millis       = uflow_q ? '0 : ms_q;
	assign seconds      = uflow_q ? '0 : sec_q;
	assign minutes      = uflow_q ? '0 : min_q;
	assign hours        = uflow_q ? '0 : hrs_q;
	assign weekday      = uflow_q ? EPOCH_WEEKDAY : wday_q;
	assign year         = uflow_q ? EPOCH_YEAR : year_q;
	assign day_of_year  = uflow_q ? 9'd1 : doy_q;
	assign month        = uflow_q ? 4'd1 : month_q;
	assign day_of_month = uflow_q ? 5'd1 : mday_q;

endmodule

`default_nettype wire

// ===== rtl/epoch_ms_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// epoch_ms_to_calendar_date: millisecond timestamp to calendar date and time
// Sequence: after the start beat the offset is applied, then eight divisions
//   run in the shared radix-16 divider (one digit per cycle), then the
//   calendar steps, and done is raised in the state after the last of them.
//   An underflowing count goes from the offset step straight to done.
// A new item is taken only while idle (busy low); the receiver cannot stall.
// Reset: arst_n idles the sequencer and clears tz_hours to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_ms_to_calendar_date #(
	parameter int STAMP_BITS = ectd_pkg::STAMP_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [STAMP_BITS-1:0]        timestamp_ms,
	output logic                              done,
	output logic [9:0]                        millis,
	output logic [5:0]                        seconds,
	output logic [5:0]                        minutes,
	output logic [4:0]                        hours,
	output logic [2:0]                        weekday,
	output logic [11:0]                       year,
	output logic [8:0]                        day_of_year,
	output logic [3:0]                        month,
	output logic [4:0]                        day_of_month,
	output logic                              underflow,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ectd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [ectd_pkg::PDATA_W-1:0] pwdata,
	output logic      [ectd_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import ectd_pkg::*;

	logic signed [4:0] tz_hours;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	ectd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tz_hours (tz_hours)
	);

	ectd_ctrl #(
		.STAMP_BITS (STAMP_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	ectd_dp #(
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk          (clk),
		.timestamp_ms (timestamp_ms),
		.tz_hours     (tz_hours),
		.cmd          (cmd),
		.stat         (stat),
		.millis       (millis),
		.seconds      (seconds),
		.minutes      (minutes),
		.hours        (hours),
		.weekday      (weekday),
		.year         (year),
		.day_of_year  (day_of_year),
		.month        (month),
		.day_of_month (day_of_month),
		.underflow    (underflow)
	);

endmodule

`default_nettype wire
